/* hdl/etl_pkg.sv */
// Shared types and constants for the expression token lexer.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package etl_pkg;

  // Text offsets count modulo the longest text; start_pos shows the low 16 bits.
  localparam int MAX_TEXT_LEN = 65536;
  localparam int POS_W        = (MAX_TEXT_LEN > 1) ? $clog2(MAX_TEXT_LEN) : 1;
  localparam int START_W      = 16;
  localparam int LEN_W        = 16;
  localparam int VALUE_W      = 31;
  localparam int OP_W         = 4;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
  localparam logic [LEN_W-1:0]   LEN_MAX   = {LEN_W{1'b1}};

  // Token queue between the lexer core and the output channel.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Token kinds.
  typedef enum logic [1:0] {
    KIND_OP  = 2'd0,
    KIND_NUM = 2'd1,
    KIND_END = 2'd2,
    KIND_ERR = 2'd3
  } kind_t;

  // Operator codes.
  localparam logic [OP_W-1:0] OP_ADD = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV = 4'd3;
  localparam logic [OP_W-1:0] OP_LP  = 4'd4;
  localparam logic [OP_W-1:0] OP_RP  = 4'd5;
  localparam logic [OP_W-1:0] OP_LT  = 4'd6;
  localparam logic [OP_W-1:0] OP_GT  = 4'd7;
  localparam logic [OP_W-1:0] OP_EQ  = 4'd8;
  localparam logic [OP_W-1:0] OP_NE  = 4'd9;
  localparam logic [OP_W-1:0] OP_LE  = 4'd10;
  localparam logic [OP_W-1:0] OP_GE  = 4'd11;
  localparam logic [OP_W-1:0] OP_NONE = 4'd0;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LP    = 8'h28;
  localparam logic [7:0] CH_RP    = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;

  // One result word.
  typedef struct packed {
    kind_t               kind;
    logic [OP_W-1:0]     op;
    logic [VALUE_W-1:0]  value;
    logic [START_W-1:0]  start;
    logic [LEN_W-1:0]    length;
    logic                ovf;
    logic                last;
  } token_t;

endpackage

/* hdl/etl_if.sv */
// Valid/ready channel interfaces for text bytes and tokens.
// Depends on etl_pkg for field widths.
`timescale 1ns / 1ps

interface etl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface etl_token_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  token_kind;
  logic [etl_pkg::OP_W-1:0]    operator_code;
  logic [etl_pkg::VALUE_W-1:0] number_value;
  logic [etl_pkg::START_W-1:0] start_pos;
  logic [etl_pkg::LEN_W-1:0]   token_length;
  logic                        overflowed;
  logic                        last_of_run;

  modport source (output valid, output token_kind, output operator_code,
                  output number_value, output start_pos, output token_length,
                  output overflowed, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input operator_code,
                  input number_value, input start_pos, input token_length,
                  input overflowed, input last_of_run, output ready);
endinterface

/* hdl/etl_queue.sv */
// Small token queue that takes up to two words per cycle and gives one.
// Depends on etl_pkg for the token type and depth.
`timescale 1ns / 1ps

module etl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_count,
  input  etl_pkg::token_t push_word [2],
  output logic            room,
  output logic            head_valid,
  output etl_pkg::token_t head_word,
  input  logic            pop
);

  etl_pkg::token_t                 store [etl_pkg::QUEUE_DEPTH];
  logic [etl_pkg::QPTR_W-1:0]      wr_ptr;
  logic [etl_pkg::QPTR_W-1:0]      rd_ptr;
  logic [etl_pkg::QCNT_W-1:0]      count;
  logic [etl_pkg::QPTR_W-1:0]      wr_ptr_plus1;
  logic                            do_pop;

  assign do_pop       = pop && (count != '0);
  assign wr_ptr_plus1 = wr_ptr + 1'b1;
  assign head_valid   = (count != '0);
  assign head_word    = store[rd_ptr];
  // Room for a worst-case pair of words, judged on the registered fill level.
  assign room = (count <= etl_pkg::QCNT_W'(etl_pkg::QUEUE_DEPTH - 2));

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + etl_pkg::QPTR_W'(push_count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + etl_pkg::QCNT_W'(push_count) - etl_pkg::QCNT_W'(do_pop);
    end
  end

  // Word storage; no reset needed for payload.
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      store[wr_ptr] <= push_word[0];
    end
    if (push_count == 2'd2) begin
      store[wr_ptr_plus1] <= push_word[1];
    end
  end

endmodule

/* hdl/etl_core.sv */
// Lexer core: input register, scanning state and token generation.
// Depends on etl_pkg and etl_if; feeds etl_queue through push_count/push_word.
`timescale 1ns / 1ps

module etl_core (
  input  logic            clk,
  input  logic            rst,
  etl_byte_if.sink        bytes,
  input  logic            room,
  output logic [1:0]      push_count,
  output etl_pkg::token_t push_word [2]
);

  typedef enum logic [2:0] {
    PEND_NONE,
    PEND_LT,
    PEND_GT,
    PEND_EQ,
    PEND_NOT
  } pend_t;

  // Input register.
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       go;

  // Scanning state.
  pend_t                        pend,       pend_next;
  logic                         num_active, num_active_next;
  logic [etl_pkg::VALUE_W-1:0]  num_acc,    num_acc_next;
  logic [etl_pkg::START_W-1:0]  num_start,  num_start_next;
  logic [etl_pkg::LEN_W-1:0]    num_len,    num_len_next;
  logic                         num_ovf,    num_ovf_next;
  logic [etl_pkg::POS_W-1:0]    position,   position_next;
  logic                         halt,       halt_next;

  // Per-byte working values.
  logic [etl_pkg::POS_W-1:0]    pos_inc;
  logic [etl_pkg::POS_W-1:0]    pos_prev;
  logic [etl_pkg::START_W-1:0]  start_here;
  logic [etl_pkg::START_W-1:0]  start_prev;
  logic                         is_digit;
  logic                         is_space;
  logic                         is_single;
  logic [etl_pkg::OP_W-1:0]     single_code;
  logic [etl_pkg::VALUE_W+3:0]  acc_times10;
  etl_pkg::token_t              tok [2];
  logic [1:0]                   n;

  function automatic etl_pkg::token_t make_tok(
    input etl_pkg::kind_t              kind,
    input logic [etl_pkg::OP_W-1:0]    op,
    input logic [etl_pkg::VALUE_W-1:0] value,
    input logic [etl_pkg::START_W-1:0] start,
    input logic [etl_pkg::LEN_W-1:0]   length,
    input logic                        ovf
  );
    etl_pkg::token_t t;
    t.kind   = kind;
    t.op     = op;
    t.value  = value;
    t.start  = start;
    t.length = length;
    t.ovf    = ovf;
    t.last   = 1'b0;
    return t;
  endfunction

  assign go          = hold_valid && room;
  assign bytes.ready = !hold_valid || go;

  // Position arithmetic modulo the text length.
  assign pos_inc  = (position == etl_pkg::POS_W'(etl_pkg::MAX_TEXT_LEN - 1)) ?
                    '0 : position + 1'b1;
  assign pos_prev = (position == '0) ?
                    etl_pkg::POS_W'(etl_pkg::MAX_TEXT_LEN - 1) : position - 1'b1;
  assign start_here = etl_pkg::START_W'(position);
  assign start_prev = etl_pkg::START_W'(pos_prev);

  // Character classes.
  assign is_digit = (hold_byte >= etl_pkg::CH_ZERO) && (hold_byte <= etl_pkg::CH_NINE);
  assign is_space = (hold_byte == etl_pkg::CH_SPACE) ||
                    ((hold_byte >= etl_pkg::CH_TAB) && (hold_byte <= etl_pkg::CH_CR));

  always_comb begin
    is_single   = 1'b1;
    single_code = etl_pkg::OP_NONE;
    case (hold_byte)
      etl_pkg::CH_PLUS:  single_code = etl_pkg::OP_ADD;
      etl_pkg::CH_MINUS: single_code = etl_pkg::OP_SUB;
      etl_pkg::CH_STAR:  single_code = etl_pkg::OP_MUL;
      etl_pkg::CH_SLASH: single_code = etl_pkg::OP_DIV;
      etl_pkg::CH_LP:    single_code = etl_pkg::OP_LP;
      etl_pkg::CH_RP:    single_code = etl_pkg::OP_RP;
      default:           is_single   = 1'b0;
    endcase
  end

  // Accumulator times ten plus the new digit, as shifts and two adds.
  assign acc_times10 = ({4'b0, num_acc} << 3) + ({4'b0, num_acc} << 1) +
                       (etl_pkg::VALUE_W + 4)'(hold_byte[3:0]);

  // Next state and up to two tokens for the held byte.
  always_comb begin
    logic scan_on;
    pend_next       = pend;
    num_active_next = num_active;
    num_acc_next    = num_acc;
    num_start_next  = num_start;
    num_len_next    = num_len;
    num_ovf_next    = num_ovf;
    position_next   = position;
    halt_next       = halt;
    tok[0]          = '0;
    tok[1]          = '0;
    n               = 2'd0;
    scan_on         = 1'b1;

    if (halt) begin
      // Ignore text until the terminating zero byte.
      scan_on = 1'b0;
      if (hold_byte == etl_pkg::CH_NUL) begin
        halt_next     = 1'b0;
        position_next = '0;
      end
    end else if (pend != PEND_NONE) begin
      pend_next = PEND_NONE;
      if (hold_byte == etl_pkg::CH_EQ) begin
        unique case (pend)
          PEND_EQ:  tok[0] = make_tok(etl_pkg::KIND_OP, etl_pkg::OP_EQ, '0,
                                      start_prev, 16'd2, 1'b0);
          PEND_NOT: tok[0] = make_tok(etl_pkg::KIND_OP, etl_pkg::OP_NE, '0,
                                      start_prev, 16'd2, 1'b0);
          PEND_LT:  tok[0] = make_tok(etl_pkg::KIND_OP, etl_pkg::OP_LE, '0,
                                      start_prev, 16'd2, 1'b0);
          default:  tok[0] = make_tok(etl_pkg::KIND_OP, etl_pkg::OP_GE, '0,
                                      start_prev, 16'd2, 1'b0);
        endcase
        n             = 2'd1;
        position_next = pos_inc;
        scan_on       = 1'b0;
      end else if (pend == PEND_LT || pend == PEND_GT) begin
        tok[0] = make_tok(etl_pkg::KIND_OP,
                          (pend == PEND_LT) ? etl_pkg::OP_LT : etl_pkg::OP_GT,
                          '0, start_prev, 16'd1, 1'b0);
        n = 2'd1;
      end else begin
        // A lone = or ! is an error; the current byte is swallowed.
        tok[0]  = make_tok(etl_pkg::KIND_ERR, etl_pkg::OP_NONE, '0,
                           start_prev, '0, 1'b0);
        n       = 2'd1;
        scan_on = 1'b0;
        if (hold_byte == etl_pkg::CH_NUL) begin
          position_next = '0;
        end else begin
          halt_next     = 1'b1;
          position_next = pos_inc;
        end
      end
    end

    if (scan_on && num_active && is_digit) begin
      // Extend the number being read.
      scan_on = 1'b0;
      if (!num_ovf) begin
        if (acc_times10 > (etl_pkg::VALUE_W + 4)'(etl_pkg::VALUE_MAX)) begin
          num_acc_next = etl_pkg::VALUE_MAX;
          num_ovf_next = 1'b1;
        end else begin
          num_acc_next = acc_times10[etl_pkg::VALUE_W-1:0];
        end
      end
      if (num_len != etl_pkg::LEN_MAX) begin
        num_len_next = num_len + 1'b1;
      end
      position_next = pos_inc;
    end else if (scan_on && num_active) begin
      // Any other byte closes the number.
      tok[n[0]] = make_tok(etl_pkg::KIND_NUM, etl_pkg::OP_NONE, num_acc,
                           num_start, num_len, num_ovf);
      n               = n + 2'd1;
      num_active_next = 1'b0;
      num_acc_next    = '0;
      num_len_next    = '0;
      num_ovf_next    = 1'b0;
    end

    if (scan_on) begin
      if (hold_byte == etl_pkg::CH_NUL) begin
        tok[n[0]] = make_tok(etl_pkg::KIND_END, etl_pkg::OP_NONE, '0,
                             start_here, '0, 1'b0);
        n               = n + 2'd1;
        num_active_next = 1'b0;
        num_acc_next    = '0;
        num_start_next  = '0;
        num_len_next    = '0;
        num_ovf_next    = 1'b0;
        position_next   = '0;
      end else if (is_space) begin
        position_next = pos_inc;
      end else if (hold_byte == etl_pkg::CH_LT) begin
        pend_next     = PEND_LT;
        position_next = pos_inc;
      end else if (hold_byte == etl_pkg::CH_GT) begin
        pend_next     = PEND_GT;
        position_next = pos_inc;
      end else if (hold_byte == etl_pkg::CH_EQ) begin
        pend_next     = PEND_EQ;
        position_next = pos_inc;
      end else if (hold_byte == etl_pkg::CH_BANG) begin
        pend_next     = PEND_NOT;
        position_next = pos_inc;
      end else if (is_single) begin
        tok[n[0]] = make_tok(etl_pkg::KIND_OP, single_code, '0,
                             start_here, 16'd1, 1'b0);
        n             = n + 2'd1;
        position_next = pos_inc;
      end else if (is_digit) begin
        num_active_next = 1'b1;
        num_acc_next    = etl_pkg::VALUE_W'(hold_byte[3:0]);
        num_start_next  = start_here;
        num_len_next    = 16'd1;
        num_ovf_next    = 1'b0;
        position_next   = pos_inc;
      end else begin
        tok[n[0]] = make_tok(etl_pkg::KIND_ERR, etl_pkg::OP_NONE, '0,
                             start_here, '0, 1'b0);
        n             = n + 2'd1;
        halt_next     = 1'b1;
        position_next = pos_inc;
      end
    end

    // Mark the final token of this byte.
    if (n == 2'd1) begin
      tok[0].last = 1'b1;
    end else if (n == 2'd2) begin
      tok[1].last = 1'b1;
    end
  end

  assign push_count  = go ? n : 2'd0;
  assign push_word[0] = tok[0];
  assign push_word[1] = tok[1];

  // Input register and scanning state.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      pend       <= PEND_NONE;
      num_active <= 1'b0;
      num_acc    <= '0;
      num_start  <= '0;
      num_len    <= '0;
      num_ovf    <= 1'b0;
      position   <= '0;
      halt       <= 1'b0;
    end else begin
      if (bytes.ready) begin
        hold_valid <= bytes.valid;
      end
      if (go) begin
        pend       <= pend_next;
        num_active <= num_active_next;
        num_acc    <= num_acc_next;
        num_start  <= num_start_next;
        num_len    <= num_len_next;
        num_ovf    <= num_ovf_next;
        position   <= position_next;
        halt       <= halt_next;
      end
    end
  end

  // Held byte payload.
  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      hold_byte <= bytes.text_byte;
    end
  end

endmodule

/* hdl/expression_token_lexer_top.sv */
// Expression token lexer: top level joining the lexer core and the token queue.
// Depends on etl_pkg, etl_if, etl_core and etl_queue.
//
// Usage:
//   Program text enters on the bytes channel, one character per word; a zero
//   byte ends a text. Tokens leave on the tokens channel: operators, numbers
//   (saturated value, start offset, length), an end token per text without
//   an error, and an error token after which the rest of that text is dropped.
//   last_of_run marks the final token caused by one input byte.
//   Throughput: one byte per cycle while the token queue has room. A byte
//   that yields two tokens leaves one extra word in the four-entry token
//   queue; intake pauses while the queue holds three or more words.
//   Token path: a byte is caught in the input register, then its tokens
//   are written into the queue and offered from its head; the core scans
//   each held byte in a single pass.
//   Reset (synchronous, active high) empties the queue and returns the lexer
//   to the start of a text at offset zero.
//   When the receiver stalls, tokens wait in the queue and bytes keep being
//   taken until it can no longer hold a worst-case pair of tokens.
`timescale 1ns / 1ps

module expression_token_lexer_top (
  input  logic        clk,
  input  logic        rst,
  etl_byte_if.sink    bytes,
  etl_token_if.source tokens
);

  logic            room;
  logic [1:0]      push_count;
  etl_pkg::token_t push_word [2];
  logic            head_valid;
  etl_pkg::token_t head_word;

  etl_core u_core (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .room       (room),
    .push_count (push_count),
    .push_word  (push_word)
  );

  etl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_word  (push_word),
    .room       (room),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (tokens.ready)
  );

  // Present the queue head on the token channel.
  assign tokens.valid         = head_valid;
  assign tokens.token_kind    = head_word.kind;
  assign tokens.operator_code = head_word.op;
  assign tokens.number_value  = head_word.value;
  assign tokens.start_pos     = head_word.start;
  assign tokens.token_length  = head_word.length;
  assign tokens.overflowed    = head_word.ovf;
  assign tokens.last_of_run   = head_word.last;

endmodule

/* hdl/etl_checker.sv */
// Port-level checks for the expression token lexer, bound to its top level.
// Depends on etl_pkg and expression_token_lexer_top.
`timescale 1ns / 1ps

module etl_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_kind,
  input logic [etl_pkg::LEN_W-1:0]  out_length,
  input logic                       out_last
);

  // Reset leaves no token on offer.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("token offered right after reset");

  // The second token of a byte is already queued when the first one leaves.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("second token of a byte missing");

  // A fresh token appears only where a byte was taken before it, held in the input register and then queued.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("token appeared without a byte two cycles earlier");

  // Number tokens always cover at least one character.
  a_num_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == etl_pkg::KIND_NUM) |-> (out_length != '0))
    else $error("number token of zero length");

endmodule

bind expression_token_lexer_top etl_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (bytes.valid),
  .in_ready   (bytes.ready),
  .out_valid  (tokens.valid),
  .out_ready  (tokens.ready),
  .out_kind   (tokens.token_kind),
  .out_length (tokens.token_length),
  .out_last   (tokens.last_of_run)
);

/* bench/tb_top.sv */
// Self-checking testbench for the expression token lexer (expression_token_lexer_top).
// Depends on etl_pkg and etl_if, plus the lexer RTL itself.
// A token predictor runs beside the design, and every token word is checked in order.
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT  = 1000;  // cycles with no word moving on either channel
  localparam int LONG_HOLD    = 80;    // receiver hold-off used to fill the token queue
  localparam int ITEM_TARGET  = 650;   // least number of bytes sent over the whole run
  localparam int REPORT_CAP   = 40;
  localparam int DRAIN_CYCLES = 16;
  localparam int SAT_DIGITS   = 24;    // well beyond the largest representable value

  // Character held back while waiting to see whether '=' follows.
  typedef enum logic [2:0] {HELD_NONE, HELD_LT, HELD_GT, HELD_EQ, HELD_BANG} held_t;
  // Receiver behaviour while not in a hold-off.
  typedef enum logic [1:0] {SINK_FULL, SINK_PATTERN, SINK_RANDOM} sink_mode_t;

  logic clk;
  logic rst;

  etl_byte_if  bytes_if ();
  etl_token_if tokens_if ();

  expression_token_lexer_top u_top (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_if),
    .tokens (tokens_if)
  );

  // Predictor state.
  held_t                       held;
  logic                        num_active;
  logic [31:0]                 num_accum;
  logic [etl_pkg::START_W-1:0] num_start;
  logic [etl_pkg::LEN_W-1:0]   num_len;
  logic                        num_ovf;
  logic [etl_pkg::POS_W-1:0]   text_pos;
  logic                        err_halt;
  etl_pkg::token_t             token_q[$];

  // Stimulus and receiver controls.
  logic               steady;
  int                 burst_left;
  sink_mode_t         sink_mode;
  logic [7:0]         sink_mask;
  logic               hold_req;
  int                 hold_left;

  // Run statistics.
  int failures;
  int bytes_sent;
  int lexed_count;
  int texts_sent;
  int tokens_seen;
  int err_tokens;
  int ovf_tokens;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic logic [etl_pkg::POS_W-1:0] next_pos(logic [etl_pkg::POS_W-1:0] p);
    return (p == etl_pkg::POS_W'(etl_pkg::MAX_TEXT_LEN - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic etl_pkg::token_t make_token(etl_pkg::kind_t k,
                                                 logic [etl_pkg::OP_W-1:0] op,
                                                 logic [etl_pkg::VALUE_W-1:0] v,
                                                 logic [etl_pkg::POS_W-1:0] s,
                                                 logic [etl_pkg::LEN_W-1:0] l,
                                                 logic o);
    etl_pkg::token_t t;
    t.kind   = k;
    t.op     = op;
    t.value  = v;
    t.start  = etl_pkg::START_W'(s);
    t.length = l;
    t.ovf    = o;
    t.last   = 1'b0;
    return t;
  endfunction

  task automatic clear_lexer();
    held       = HELD_NONE;
    num_active = 1'b0;
    num_accum  = '0;
    num_start  = '0;
    num_len    = '0;
    num_ovf    = 1'b0;
    text_pos   = '0;
    err_halt   = 1'b0;
  endtask

  // Works out the tokens that one accepted text byte causes and queues them.
  task automatic lex_byte(input logic [7:0] b);
    etl_pkg::token_t           step_q[$];
    logic [etl_pkg::POS_W-1:0] here;
    logic [etl_pkg::POS_W-1:0] prev;
    logic [35:0]               wide;
    logic [etl_pkg::OP_W-1:0]  code;
    held_t                     h;
    logic                      done;
    here = text_pos;
    prev = (text_pos == '0) ? etl_pkg::POS_W'(etl_pkg::MAX_TEXT_LEN - 1) : text_pos - 1'b1;
    done = 1'b0;
    if (err_halt) begin
      // After an error everything up to the terminating zero is dropped silently.
      if (b == etl_pkg::CH_NUL) clear_lexer();
      done = 1'b1;
    end else begin
      lexed_count++;
      if (held != HELD_NONE) begin
        h    = held;
        held = HELD_NONE;
        if (b == etl_pkg::CH_EQ) begin
          case (h)
            HELD_EQ:   code = etl_pkg::OP_EQ;
            HELD_BANG: code = etl_pkg::OP_NE;
            HELD_LT:   code = etl_pkg::OP_LE;
            default:   code = etl_pkg::OP_GE;
          endcase
          step_q.push_back(make_token(etl_pkg::KIND_OP, code, '0, prev,
                                      etl_pkg::LEN_W'(2), 1'b0));
          text_pos = next_pos(text_pos);
          done     = 1'b1;
        end else if (h == HELD_LT || h == HELD_GT) begin
          code = (h == HELD_LT) ? etl_pkg::OP_LT : etl_pkg::OP_GT;
          step_q.push_back(make_token(etl_pkg::KIND_OP, code, '0, prev,
                                      etl_pkg::LEN_W'(1), 1'b0));
        end else begin
          // A lone '=' or '!' is an error reported at its own offset.
          step_q.push_back(make_token(etl_pkg::KIND_ERR, etl_pkg::OP_NONE, '0, prev,
                                      '0, 1'b0));
          err_halt = 1'b1;
          if (b == etl_pkg::CH_NUL) clear_lexer();
          else text_pos = next_pos(text_pos);
          done = 1'b1;
        end
      end
    end

    // A number in progress either grows or is closed by this byte.
    if (!done && num_active) begin
      if (b >= etl_pkg::CH_ZERO && b <= etl_pkg::CH_NINE) begin
        if (!num_ovf) begin
          wide = 36'(num_accum) * 10 + 36'(b - etl_pkg::CH_ZERO);
          if (wide > 36'(etl_pkg::VALUE_MAX)) begin
            wide    = 36'(etl_pkg::VALUE_MAX);
            num_ovf = 1'b1;
          end
          num_accum = wide[31:0];
        end
        if (num_len != etl_pkg::LEN_MAX) num_len++;
        text_pos = next_pos(text_pos);
        done     = 1'b1;
      end else begin
        step_q.push_back(make_token(etl_pkg::KIND_NUM, etl_pkg::OP_NONE,
                                    num_accum[etl_pkg::VALUE_W-1:0],
                                    etl_pkg::POS_W'(num_start), num_len, num_ovf));
        num_active = 1'b0;
        num_accum  = '0;
        num_len    = '0;
        num_ovf    = 1'b0;
      end
    end

    // The byte itself.
    if (!done) begin
      if (b == etl_pkg::CH_NUL) begin
        step_q.push_back(make_token(etl_pkg::KIND_END, etl_pkg::OP_NONE, '0, here,
                                    '0, 1'b0));
        clear_lexer();
      end else if (b == etl_pkg::CH_SPACE ||
                   (b >= etl_pkg::CH_TAB && b <= etl_pkg::CH_CR)) begin
        text_pos = next_pos(text_pos);
      end else if (b == etl_pkg::CH_LT || b == etl_pkg::CH_GT || b == etl_pkg::CH_EQ ||
                   b == etl_pkg::CH_BANG) begin
        case (b)
          etl_pkg::CH_LT: held = HELD_LT;
          etl_pkg::CH_GT: held = HELD_GT;
          etl_pkg::CH_EQ: held = HELD_EQ;
          default:        held = HELD_BANG;
        endcase
        text_pos = next_pos(text_pos);
      end else if (b == etl_pkg::CH_PLUS || b == etl_pkg::CH_MINUS ||
                   b == etl_pkg::CH_STAR || b == etl_pkg::CH_SLASH ||
                   b == etl_pkg::CH_LP || b == etl_pkg::CH_RP) begin
        case (b)
          etl_pkg::CH_PLUS:  code = etl_pkg::OP_ADD;
          etl_pkg::CH_MINUS: code = etl_pkg::OP_SUB;
          etl_pkg::CH_STAR:  code = etl_pkg::OP_MUL;
          etl_pkg::CH_SLASH: code = etl_pkg::OP_DIV;
          etl_pkg::CH_LP:    code = etl_pkg::OP_LP;
          default:           code = etl_pkg::OP_RP;
        endcase
        step_q.push_back(make_token(etl_pkg::KIND_OP, code, '0, here,
                                    etl_pkg::LEN_W'(1), 1'b0));
        text_pos = next_pos(text_pos);
      end else if (b >= etl_pkg::CH_ZERO && b <= etl_pkg::CH_NINE) begin
        num_active = 1'b1;
        num_accum  = 32'(b - etl_pkg::CH_ZERO);
        num_start  = etl_pkg::START_W'(here);
        num_len    = etl_pkg::LEN_W'(1);
        num_ovf    = 1'b0;
        text_pos   = next_pos(text_pos);
      end else begin
        step_q.push_back(make_token(etl_pkg::KIND_ERR, etl_pkg::OP_NONE, '0, here,
                                    '0, 1'b0));
        err_halt = 1'b1;
        text_pos = next_pos(text_pos);
      end
    end

    // The final token caused by this byte carries the marker.
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) token_q.push_back(step_q[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Byte sender
  // ---------------------------------------------------------------------------

  // Offers one byte until it is taken, then, unless steady, idles according to the burst pattern.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    bytes_if.valid     <= 1'b1;
    bytes_if.text_byte <= b;
    do @(posedge clk); while (!bytes_if.ready);
    lex_byte(b);
    bytes_sent++;
    if (b == etl_pkg::CH_NUL) texts_sent++;
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk);
          bytes_if.valid <= 1'b0;
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Token receiver and checker
  // ---------------------------------------------------------------------------

  // The receiver stalls on its own pattern; a hold-off request overrides it.
  initial begin : drive_ready
    tokens_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        tokens_if.ready <= 1'b0;
      end else begin
        case (sink_mode)
          SINK_FULL: tokens_if.ready <= 1'b1;
          SINK_PATTERN: begin
            tokens_if.ready <= sink_mask[0];
            sink_mask = {sink_mask[0], sink_mask[7:1]};
          end
          default: tokens_if.ready <= ($urandom_range(0, 9) < 6);
        endcase
      end
    end
  end

  // Counts a failure; detailed reports stop after a cap to keep the log short.
  function automatic logic log_failure();
    failures++;
    return failures <= REPORT_CAP;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (log_failure()) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_tokens
    etl_pkg::token_t want;
    if (!rst && tokens_if.valid && tokens_if.ready) begin
      tokens_seen++;
      if (token_q.size() == 0) begin
        if (log_failure())
          $error("unexpected token word: kind %0d, start %0d",
                 tokens_if.token_kind, tokens_if.start_pos);
      end else begin
        want = token_q.pop_front();
        if (want.kind == etl_pkg::KIND_ERR) err_tokens++;
        if (want.ovf) ovf_tokens++;
        check_field("token_kind", 32'(want.kind), 32'(tokens_if.token_kind));
        check_field("operator_code", 32'(want.op), 32'(tokens_if.operator_code));
        check_field("number_value", 32'(want.value), 32'(tokens_if.number_value));
        check_field("start_pos", 32'(want.start), 32'(tokens_if.start_pos));
        check_field("token_length", 32'(want.length), 32'(tokens_if.token_length));
        check_field("overflowed", 32'(want.ovf), 32'(tokens_if.overflowed));
        check_field("last_of_run", 32'(want.last), 32'(tokens_if.last_of_run));
      end
    end
  end

  // Ends the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (bytes_if.valid && bytes_if.ready) || (tokens_if.valid && tokens_if.ready))
    begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles, %0d tokens outstanding.",
               idle_cycles, token_q.size());
      $display("** expression_token_lexer_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every operator, with '<' and '>' closed by another operator (two tokens at once).
  task automatic test_operators();
    send_text("(+-*/)<+>+==!=<=>=");
    send_byte(etl_pkg::CH_NUL);
  endtask

  // Numbers closed by whitespace, by a '>', and by the end of text.
  task automatic test_numbers();
    send_text("0 42\t<");
    send_byte(etl_pkg::CH_CR);
    send_text("7");
    send_byte(etl_pkg::CH_NUL);
    send_text("9>");
    send_byte(etl_pkg::CH_NUL);
  endtask

  // Lone '=' and '!', stray characters, and the silent tail after an error.
  task automatic test_errors();
    send_text("=x");
    send_byte(etl_pkg::CH_NUL);
    send_text("!");
    send_byte(etl_pkg::CH_NUL);
    send_byte(8'hFF);
    send_text("+");
    send_byte(etl_pkg::CH_NUL);
    send_text("1 a2");
    send_byte(etl_pkg::CH_NUL);
  endtask

  // A number far larger than the value range: the value saturates and the
  // token is flagged, while its length still counts every digit.
  task automatic test_saturation();
    steady    = 1'b1;
    sink_mode = SINK_FULL;
    send_text("7 ");
    send_byte(8'($urandom_range(etl_pkg::CH_ZERO + 1, etl_pkg::CH_NINE)));
    repeat (SAT_DIGITS - 1)
      send_byte(8'($urandom_range(etl_pkg::CH_ZERO, etl_pkg::CH_NINE)));
    send_text("+");
    send_byte(etl_pkg::CH_NUL);
    steady = 1'b0;
  endtask

  // The receiver holds off while bytes keep coming, so the token queue fills.
  task automatic test_backpressure();
    steady   = 1'b1;
    hold_req = 1'b1;
    send_text("1+22*(3<4)>=5!=6-7/8<9>0");
    send_byte(etl_pkg::CH_NUL);
    steady = 1'b0;
  endtask

  // One random text: mostly well-formed tokens, sometimes broken, sometimes noise.
  task automatic random_text();
    logic [7:0] singles[8] = '{etl_pkg::CH_PLUS, etl_pkg::CH_MINUS, etl_pkg::CH_STAR,
                               etl_pkg::CH_SLASH, etl_pkg::CH_LP, etl_pkg::CH_RP,
                               etl_pkg::CH_LT, etl_pkg::CH_GT};
    logic [7:0] pairs[4]   = '{etl_pkg::CH_LT, etl_pkg::CH_GT, etl_pkg::CH_EQ,
                               etl_pkg::CH_BANG};
    int         pick;
    int         digits;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 14)) begin
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
          digits = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14)
                                               : $urandom_range(1, 4);
          repeat (digits)
            send_byte(8'($urandom_range(etl_pkg::CH_ZERO, etl_pkg::CH_NINE)));
        end else if (pick < 14) begin
          send_byte(singles[$urandom_range(0, 7)]);
        end else if (pick < 18) begin
          send_byte(pairs[$urandom_range(0, 3)]);
          send_byte(etl_pkg::CH_EQ);
        end else if (pick == 18) begin
          send_byte($urandom_range(0, 1) ? etl_pkg::CH_EQ : etl_pkg::CH_BANG);
        end else begin
          send_byte(8'($urandom_range(1, 255)));
        end
        // Whitespace between tokens, from the full set of blank characters.
        if ($urandom_range(0, 1)) begin
          repeat ($urandom_range(1, 2))
            send_byte(($urandom_range(0, 5) == 0) ?
                      etl_pkg::CH_SPACE :
                      8'($urandom_range(etl_pkg::CH_TAB, etl_pkg::CH_CR)));
        end
      end
    end
    send_byte(etl_pkg::CH_NUL);
  endtask

  // Random texts until the run has sent its share of bytes.
  task automatic test_random_texts();
    while (bytes_sent < ITEM_TARGET) begin
      sink_mode = sink_mode_t'($urandom_range(0, 2));
      sink_mask = 8'($urandom_range(1, 255));
      steady    = ($urandom_range(0, 4) == 0);
      random_text();
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    rst                = 1'b1;
    bytes_if.valid     = 1'b0;
    bytes_if.text_byte = '0;
    steady             = 1'b0;
    burst_left         = 0;
    sink_mode          = SINK_RANDOM;
    sink_mask          = 8'b1011_0111;
    hold_req           = 1'b0;
    hold_left          = 0;
    failures           = 0;
    bytes_sent         = 0;
    lexed_count        = 0;
    texts_sent         = 0;
    tokens_seen        = 0;
    err_tokens         = 0;
    ovf_tokens         = 0;
    idle_cycles        = 0;
    clear_lexer();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_operators();
    test_numbers();
    sink_mode = SINK_PATTERN;
    test_errors();
    test_saturation();
    sink_mode = SINK_RANDOM;
    test_backpressure();
    test_random_texts();

    // Let every outstanding token arrive, then watch for strays.
    @(negedge clk);
    bytes_if.valid <= 1'b0;
    sink_mode = SINK_FULL;
    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d texts (%0d scanned); checked %0d tokens.",
             bytes_sent, texts_sent, lexed_count, tokens_seen);
    $display("Covered operators, numbers, %0d error tokens, %0d saturated numbers, stalls.",
             err_tokens, ovf_tokens);
    if (failures == 0) begin
      $display("** expression_token_lexer_top: PASSED **");
    end else begin
      $display("%0d mismatches found.", failures);
      $display("** expression_token_lexer_top: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/etl_pkg.sv
hdl/etl_if.sv
hdl/etl_queue.sv
hdl/etl_core.sv
hdl/expression_token_lexer_top.sv
hdl/etl_checker.sv
bench/tb_top.sv
